FILE: rtl/id_hash_to_hls_color_top_defines.svh
// Assertion macros for the identifier hash to color block.
`ifndef ID_HASH_TO_HLS_COLOR_TOP_DEFINES_SVH
`define ID_HASH_TO_HLS_COLOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IDHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IDHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/idhc_pkg.sv
// Shared types, constants and functions of the identifier hash to color block.
package idhc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_REGS   = 6;
  localparam int REG_ADDR_W = 5;
  localparam int REG_IDX_W  = REG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_HUE_CENTER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HUE_SPAN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAT_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAT_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_MIN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_MAX  = 3'd5;

  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'd45875, 16'd11796, 16'd36045, 16'd55706, 16'd40632, 16'd49807
  };

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // hash fields: hue offset 12 bits, saturation and lightness 10 bits each
  localparam int HB_W = 12;
  localparam int SL_W = 10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_H,
    S_DIV_S,
    S_DIV_L,
    S_MUL_H,
    S_LERP_S0,
    S_LERP_S1,
    S_LERP_L0,
    S_LERP_L1,
    S_SET_L,
    S_PROD_LS,
    S_SET_Q,
    S_SET_P,
    S_CH_PREP,
    S_CH_MUL,
    S_CH_RES
  } seq_state_t;

  typedef enum logic [1:0] {
    RGN_UP,
    RGN_TOP,
    RGN_DOWN,
    RGN_LOW
  } ramp_t;

  typedef struct packed {
    logic start;
    logic hue;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: rtl/idhc_crc.sv
// Running CRC-32 register, one byte per transfer, restarts after the last byte.
module idhc_crc import idhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  logic        last,
  input  logic [7:0]  data,
  output logic [31:0] hash
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] crc_upd;

  assign crc_upd = crc_byte(crc_r, data);
  assign hash    = crc_upd ^ CRC_INIT;

  always_comb begin
    crc_nxt = crc_r;
    if (upd) begin
      crc_nxt = last ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

FILE: rtl/idhc_div.sv
// Rounded division of a hash field by 4095 or 1023, result ready in the cycle after start.
module idhc_div import idhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctl_t           ctl,
  input  logic [HB_W-1:0]    field,
  output div_sts_t           sts,
  output logic [FRAC_BITS:0] quot
);

  // v / (2^k - 1) is the k-bit field repeated after the binary point
  localparam int HREP = (FRAC_BITS + HB_W) / HB_W;
  localparam int SREP = (FRAC_BITS + SL_W) / SL_W;

  logic [HREP*HB_W-1:0] hpat;
  logic [SREP*SL_W-1:0] spat;
  logic [FRAC_BITS:0]   head;
  logic [FRAC_BITS+1:0] rnd_sum;
  logic                 done_r, done_nxt;
  logic [FRAC_BITS:0]   quot_r, quot_nxt;

  assign hpat    = {HREP{field}};
  assign spat    = {SREP{field[SL_W-1:0]}};
  assign head    = ctl.hue ? hpat[HREP*HB_W-1 -: FRAC_BITS+1]
                           : spat[SREP*SL_W-1 -: FRAC_BITS+1];
  // round to nearest on the first dropped bit
  assign rnd_sum = {1'b0, head} + (FRAC_BITS+2)'(1);

  always_comb begin
    done_nxt = ctl.start;
    quot_nxt = quot_r;
    if (ctl.start) begin
      quot_nxt = rnd_sum[FRAC_BITS+1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

  assign sts.done = done_r;
  assign quot     = quot_r;

endmodule

FILE: rtl/idhc_mac.sv
// Shared multiply-accumulate unit with registered accumulator.
module idhc_mac import idhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic [FRAC_BITS+2:0]      a,
  input  logic [FRAC_BITS+2:0]      b,
  output logic [2*FRAC_BITS+6:0]    acc
);

  localparam int MW = FRAC_BITS + 3;
  localparam int AW = 2 * MW + 1;

  logic [2*MW-1:0] prod;
  logic [AW-1:0]   acc_r, acc_nxt;

  assign prod = a * b;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = (ctl.accum ? acc_r : '0) + AW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: rtl/id_hash_to_hls_color_top.sv
// Top level: identifier CRC-32 to HLS color, sequencer, registers and output stage.
// Bytes that are not last are taken one per cycle while the sequencer is idle, with no result.
// A last byte starts the color sequence: three divisions plus 18 multiply and
// select steps on one shared MAC unit, after which out_tvalid rises.
// in_tready is low until the sequence ends, and longer while the output register is full.
// Synchronous active-low reset: CRC to all ones, registers to their defaults.
`include "id_hash_to_hls_color_top_defines.svh"

module id_hash_to_hls_color_top import idhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [REG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // id_byte[7:0]
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [79:0]           out_tdata   // red[15:0] green[31:16] blue[47:32] id_hash[79:48]
);

  localparam int MW = FRAC_BITS + 3;
  localparam int AW = 2 * MW + 1;
  localparam longint unsigned UNIT_L = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   UNIT_V  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] HALF_V  = {1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS-1:0] THIRD_V = FRAC_BITS'((UNIT_L + 64'd1) / 64'd3);
  localparam logic [FRAC_BITS-1:0] SIXTH_V = FRAC_BITS'((UNIT_L + 64'd3) / 64'd6);
  localparam logic [FRAC_BITS-1:0] TT_V    = FRAC_BITS'((64'd2 * UNIT_L + 64'd1) / 64'd3);

  function automatic logic [FRAC_BITS-1:0] frq(input logic [15:0] v);
    logic [FRAC_BITS+15:0] e;
    e = {v, {FRAC_BITS{1'b0}}};
    return e[FRAC_BITS+15:16];
  endfunction

  function automatic logic [15:0] toq(input logic [FRAC_BITS:0] c);
    logic [FRAC_BITS+16:0] e;
    logic [16:0]           v;
    e = {c, 16'd0};
    v = e[FRAC_BITS+16:FRAC_BITS];
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  // configuration registers
  logic [15:0]          regs_r [NUM_REGS];
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[REG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx < REG_IDX_W'(NUM_REGS)) ? {16'd0, regs_r[cfg_idx]} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= REG_RESET[i];
      end
    end else if (cfg_wr && (cfg_idx < REG_IDX_W'(NUM_REGS))) begin
      regs_r[cfg_idx] <= cfg_pwdata[15:0];
    end
  end

  logic [FRAC_BITS-1:0] center, span, smin, smax, lmin, lmax;
  assign center = frq(regs_r[REG_HUE_CENTER]);
  assign span   = frq(regs_r[REG_HUE_SPAN]);
  assign smin   = frq(regs_r[REG_SAT_MIN]);
  assign smax   = frq(regs_r[REG_SAT_MAX]);
  assign lmin   = frq(regs_r[REG_LIGHT_MIN]);
  assign lmax   = frq(regs_r[REG_LIGHT_MAX]);

  // sequencer and datapath state
  seq_state_t           state_r, state_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [79:0]          out_tdata_r, out_tdata_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic [31:0]          hash_r, hash_nxt;
  logic [FRAC_BITS:0]   hp_r, hp_nxt, sp_r, sp_nxt, lp_r, lp_nxt;
  logic [FRAC_BITS-1:0] h_r, h_nxt, s_r, s_nxt, l_r, l_nxt;
  logic [FRAC_BITS:0]   q_r, q_nxt, p_r, p_nxt, d_r, d_nxt;
  logic [MW-1:0]        f_r, f_nxt;
  ramp_t                rgn_r, rgn_nxt;
  logic [FRAC_BITS:0]   chan_r [3];
  logic [FRAC_BITS:0]   chan_nxt [3];

  logic                 in_rdy;
  logic                 in_acc;
  logic                 out_free;
  logic [31:0]          crc_hash;
  div_ctl_t             div_ctl;
  div_sts_t             div_sts;
  logic [HB_W-1:0]      div_field;
  logic [FRAC_BITS:0]   div_quot;
  mac_ctl_t             mac_ctl;
  logic [MW-1:0]        mac_a, mac_b;
  logic [AW-1:0]        mac_acc;
  logic [AW-1:0]        rnd_w;
  logic [FRAC_BITS+2:0] rnd_v;
  logic [FRAC_BITS:0]   sp_inv, lp_inv;

  assign in_acc   = in_tvalid && in_rdy;
  assign out_free = !out_tvalid_r || out_tready;
  assign rnd_w    = mac_acc + AW'(HALF_V);
  assign rnd_v    = rnd_w[FRAC_BITS +: FRAC_BITS+3];
  assign sp_inv   = UNIT_V - sp_r;
  assign lp_inv   = UNIT_V - lp_r;

  idhc_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (in_acc),
    .last  (in_tlast),
    .data  (in_tdata),
    .hash  (crc_hash)
  );

  idhc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .field (div_field),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  idhc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_acc && in_tlast) state_nxt = S_DIV_H;
      S_DIV_H:   if (div_sts.done) state_nxt = S_DIV_S;
      S_DIV_S:   if (div_sts.done) state_nxt = S_DIV_L;
      S_DIV_L:   if (div_sts.done) state_nxt = S_MUL_H;
      S_MUL_H:   state_nxt = S_LERP_S0;
      S_LERP_S0: state_nxt = S_LERP_S1;
      S_LERP_S1: state_nxt = S_LERP_L0;
      S_LERP_L0: state_nxt = S_LERP_L1;
      S_LERP_L1: state_nxt = S_SET_L;
      S_SET_L:   state_nxt = S_PROD_LS;
      S_PROD_LS: state_nxt = S_SET_Q;
      S_SET_Q:   state_nxt = S_SET_P;
      S_SET_P:   state_nxt = S_CH_PREP;
      S_CH_PREP: state_nxt = S_CH_MUL;
      S_CH_MUL:  state_nxt = S_CH_RES;
      S_CH_RES: begin
        if (ch_r != 2'd2) begin
          state_nxt = S_CH_PREP;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    in_rdy    = 1'b0;
    div_ctl   = '0;
    div_field = '0;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    case (state_r)
      S_IDLE: in_rdy = 1'b1;
      S_DIV_H: begin
        div_ctl.start = !div_sts.done;
        div_ctl.hue   = 1'b1;
        div_field     = hash_r[31:20];
      end
      S_DIV_S: begin
        div_ctl.start = !div_sts.done;
        div_field     = HB_W'(hash_r[19:10]);
      end
      S_DIV_L: begin
        div_ctl.start = !div_sts.done;
        div_field     = HB_W'(hash_r[SL_W-1:0]);
      end
      S_MUL_H: begin
        mac_ctl.en = 1'b1;
        mac_a      = MW'(hp_r);
        mac_b      = MW'(span);
      end
      S_LERP_S0: begin
        mac_ctl.en = 1'b1;
        mac_a      = MW'(smin);
        mac_b      = MW'(sp_inv);
      end
      S_LERP_S1: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MW'(smax);
        mac_b         = MW'(sp_r);
      end
      S_LERP_L0: begin
        mac_ctl.en = 1'b1;
        mac_a      = MW'(lmin);
        mac_b      = MW'(lp_inv);
      end
      S_LERP_L1: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MW'(lmax);
        mac_b         = MW'(lp_r);
      end
      S_PROD_LS: begin
        mac_ctl.en = 1'b1;
        mac_a      = MW'(l_r);
        mac_b      = MW'(s_r);
      end
      S_CH_MUL: begin
        mac_ctl.en = 1'b1;
        mac_a      = MW'(d_r);
        mac_b      = f_r;
      end
      default: ;
    endcase
  end

  // datapath next values
  logic [FRAC_BITS-1:0] t_v;
  logic [FRAC_BITS+1:0] q_sum;
  logic [FRAC_BITS:0]   two_l, p_tmp;
  logic [FRAC_BITS+3:0] ramp_v;
  logic [FRAC_BITS:0]   ch_val;

  always_comb begin
    hash_nxt = hash_r;
    hp_nxt   = hp_r;
    sp_nxt   = sp_r;
    lp_nxt   = lp_r;
    h_nxt    = h_r;
    s_nxt    = s_r;
    l_nxt    = l_r;
    q_nxt    = q_r;
    p_nxt    = p_r;
    d_nxt    = d_r;
    f_nxt    = f_r;
    rgn_nxt  = rgn_r;
    ch_nxt   = ch_r;
    for (int i = 0; i < 3; i++) begin
      chan_nxt[i] = chan_r[i];
    end
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (ch_r)
      2'd0:    t_v = h_r + THIRD_V;
      2'd2:    t_v = h_r - THIRD_V;
      default: t_v = h_r;
    endcase
    q_sum  = (l_r < HALF_V)
             ? (FRAC_BITS+2)'(l_r) + (FRAC_BITS+2)'(rnd_v)
             : (FRAC_BITS+2)'(l_r) + (FRAC_BITS+2)'(s_r) - (FRAC_BITS+2)'(rnd_v);
    two_l  = {l_r, 1'b0};
    p_tmp  = (two_l > q_r) ? two_l - q_r : '0;
    ramp_v = (FRAC_BITS+4)'(p_r) + (FRAC_BITS+4)'(rnd_v);

    case (rgn_r)
      RGN_UP, RGN_DOWN:
        ch_val = (ramp_v > (FRAC_BITS+4)'(q_r)) ? q_r : ramp_v[FRAC_BITS:0];
      RGN_TOP: ch_val = q_r;
      default: ch_val = p_r;
    endcase

    case (state_r)
      S_IDLE:    if (in_acc && in_tlast) hash_nxt = crc_hash;
      S_DIV_H:   if (div_sts.done) hp_nxt = div_quot;
      S_DIV_S:   if (div_sts.done) sp_nxt = div_quot;
      S_DIV_L:   if (div_sts.done) lp_nxt = div_quot;
      S_LERP_S0: h_nxt = center + rnd_v[FRAC_BITS-1:0] - (span >> 1);
      S_LERP_L0: s_nxt = rnd_v[FRAC_BITS-1:0];
      S_SET_L:   l_nxt = rnd_v[FRAC_BITS-1:0];
      S_SET_Q:   q_nxt = q_sum[FRAC_BITS:0];
      S_SET_P: begin
        p_nxt  = (p_tmp > q_r) ? q_r : p_tmp;
        ch_nxt = 2'd0;
      end
      S_CH_PREP: begin
        d_nxt = q_r - p_r;
        if (t_v < SIXTH_V) begin
          rgn_nxt = RGN_UP;
          f_nxt   = (MW'(t_v) << 2) + (MW'(t_v) << 1);
        end else if (t_v < HALF_V) begin
          rgn_nxt = RGN_TOP;
          f_nxt   = '0;
        end else if (t_v < TT_V) begin
          rgn_nxt = RGN_DOWN;
          f_nxt   = (MW'(TT_V - t_v) << 2) + (MW'(TT_V - t_v) << 1);
        end else begin
          rgn_nxt = RGN_LOW;
          f_nxt   = '0;
        end
      end
      S_CH_RES: begin
        chan_nxt[ch_r] = ch_val;
        if (ch_r != 2'd2) begin
          ch_nxt = ch_r + 2'd1;
        end else if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {hash_r, toq(ch_val), toq(chan_r[1]), toq(chan_r[0])};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      ch_r         <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      ch_r         <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    hash_r      <= hash_nxt;
    hp_r        <= hp_nxt;
    sp_r        <= sp_nxt;
    lp_r        <= lp_nxt;
    h_r         <= h_nxt;
    s_r         <= s_nxt;
    l_r         <= l_nxt;
    q_r         <= q_nxt;
    p_r         <= p_nxt;
    d_r         <= d_nxt;
    f_r         <= f_nxt;
    rgn_r       <= rgn_nxt;
    for (int i = 0; i < 3; i++) begin
      chan_r[i] <= chan_nxt[i];
    end
  end

  assign in_tready  = in_rdy;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `IDHC_ASSERT_NOW(a_div_done_in_div, div_sts.done, (state_r == S_DIV_H) || (state_r == S_DIV_S) || (state_r == S_DIV_L), "divider done outside a divide step")
  `IDHC_ASSERT_NEXT(a_last_blocks_input, in_tvalid && in_tready && in_tlast, !in_tready, "input still ready after last byte")
  `IDHC_ASSERT_NEXT(a_out_only_from_seq, (state_r != S_CH_RES) && !out_tvalid_r, !out_tvalid_r, "result valid without finishing the sequence")

endmodule
